### hw/rtl/mdrp_pkg.sv
package mdrp_pkg;

   localparam int MAX_DIFE_DEFAULT = 10;

   localparam logic [7:0] FILLER_DIF  = 8'h2F;
   localparam logic [3:0] CODING_VAR  = 4'hD;
   localparam logic [3:0] CODING_SPEC = 4'hF;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_STOP   = 2'd2;
   localparam logic [1:0] KIND_TRUNC  = 2'd3;

   typedef enum logic [2:0] {
      PH_DIF,
      PH_DIFE,
      PH_VIF,
      PH_VIFE,
      PH_VARLEN,
      PH_DATA
   } phase_type;

   // one classified input byte, as it travels from the front to the back
   typedef struct packed {
      logic [7:0] data;
      logic       eot;
      logic       filler;
      logic       bad;
      logic       var_len;
      logic [3:0] fixed_len;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  measure_type;
      logic [3:0]  data_coding;
      logic [6:0]  vif_code;
      logic [40:0] storage_number;
      logic [19:0] tariff_number;
      logic [9:0]  subunit_number;
      logic [7:0]  record_length;
      logic [7:0]  data_value;
      logic [7:0]  byte_position;
      logic        record_last;
   } rsp_type;

   // data length by DIF coding; variable and special codes give zero here
   function automatic logic [3:0] coding_len(input logic [3:0] coding);
      logic [3:0] len;
      begin
         unique case (coding)
            4'h0, 4'h8: len = 4'd0;
            4'h1, 4'h9: len = 4'd1;
            4'h2, 4'hA: len = 4'd2;
            4'h3, 4'hB: len = 4'd3;
            4'h4, 4'h5, 4'hC: len = 4'd4;
            4'h6, 4'hE: len = 4'd6;
            4'h7: len = 4'd8;
            default: len = 4'd0;
         endcase
         return len;
      end
   endfunction

endpackage

### hw/rtl/mdrp_front.sv
module mdrp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [7:0]        req_in_byte,
   input  logic              req_end_of_telegram,
   output logic              cmd_valid,
   output mdrp_pkg::cmd_type cmd_item,
   input  logic              cmd_pop
);
   import mdrp_pkg::*;

   cmd_type    cmd_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    classified;
   logic       do_push, do_pop;

   always_comb begin
      classified.data      = req_in_byte;
      classified.eot       = req_end_of_telegram;
      classified.filler    = (req_in_byte == FILLER_DIF);
      classified.bad       = (req_in_byte[3:0] == CODING_SPEC) && (req_in_byte != FILLER_DIF);
      classified.var_len   = (req_in_byte[3:0] == CODING_VAR);
      classified.fixed_len = coding_len(req_in_byte[3:0]);
   end

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_item  = cmd_mem_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         cmd_mem_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

### hw/rtl/mdrp_back.sv
module mdrp_back #(
   parameter int MAX_DIFE = mdrp_pkg::MAX_DIFE_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  mdrp_pkg::cmd_type cmd_item,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output mdrp_pkg::rsp_type rsp_item
);
   import mdrp_pkg::*;

   localparam logic [3:0] MaxDife = 4'(MAX_DIFE);

   phase_type   phase_ff, phase_in, phase_step;
   logic        halted_ff, halted_in, halt_step;
   logic [7:0]  held_dif_ff, held_dif_in;
   logic        held_var_ff, held_var_in;
   logic [3:0]  held_len_ff, held_len_in;
   logic [3:0]  dife_count_ff, dife_count_in;
   logic [40:0] storage_ff, storage_in;
   logic [19:0] tariff_ff, tariff_in;
   logic [9:0]  subunit_ff, subunit_in;
   logic [6:0]  held_vif_ff, held_vif_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]  position_ff, position_in;
   logic [7:0]  rec_len_ff, rec_len_in;
   logic [7:0]  rec_start_ff, rec_start_in;

   rsp_type     rsp_mem_ff [2];
   logic        out_wr_ff, out_rd_ff;
   logic [1:0]  out_count_ff, out_count_in;

   logic [7:0]  b;
   logic        eot;
   logic [7:0]  next_pos;
   logic        take;
   logic        res_valid;
   logic        was_data;
   logic [1:0]  res_kind;
   logic [7:0]  res_value, res_pos;
   logic        res_last;
   rsp_type     res;
   logic        out_write, out_read;

   logic [5:0]  st_shift;
   logic [63:0] st_bits;
   logic [31:0] tf_bits;
   logic [15:0] su_bits;

   assign b        = cmd_item.data;
   assign eot      = cmd_item.eot;
   assign next_pos = position_ff + 8'd1;

   assign rsp_empty = (out_count_ff == 2'd0);
   assign rsp_item  = rsp_mem_ff[out_rd_ff];
   assign out_read  = rsp_pop && !rsp_empty;
   assign take      = cmd_valid && ((out_count_ff != 2'd2) || out_read);
   assign cmd_pop   = take;
   assign out_write = take && res_valid;

   assign st_shift = {dife_count_ff, 2'b00} + 6'd1;
   assign st_bits  = {60'd0, b[3:0]} << st_shift;
   assign tf_bits  = {30'd0, b[5:4]} << {dife_count_ff, 1'b0};
   assign su_bits  = {15'd0, b[6]} << dife_count_ff;

   // parse phase
   always_comb begin
      phase_step = phase_ff;
      halt_step  = halted_ff;
      if (!halted_ff) begin
         unique case (phase_ff)
            PH_DIF: begin
               if (!cmd_item.filler) begin
                  if (cmd_item.bad) begin
                     halt_step = 1'b1;
                  end else begin
                     phase_step = b[7] ? PH_DIFE : PH_VIF;
                  end
               end
            end
            PH_DIFE: begin
               if (!b[7]) phase_step = PH_VIF;
            end
            PH_VIF, PH_VIFE: begin
               if (!b[7]) begin
                  if (held_var_ff) phase_step = PH_VARLEN;
                  else if (held_len_ff == 4'd0) phase_step = PH_DIF;
                  else phase_step = PH_DATA;
               end else begin
                  phase_step = PH_VIFE;
               end
            end
            PH_VARLEN: begin
               phase_step = (b == 8'd0) ? PH_DIF : PH_DATA;
            end
            PH_DATA: begin
               if (bytes_left_ff <= 8'd1) phase_step = PH_DIF;
            end
            default: phase_step = PH_DIF;
         endcase
      end
      phase_in  = eot ? PH_DIF : phase_step;
      halted_in = eot ? 1'b0 : halt_step;
   end

   // record fields and result
   always_comb begin
      held_dif_in   = held_dif_ff;
      held_var_in   = held_var_ff;
      held_len_in   = held_len_ff;
      dife_count_in = dife_count_ff;
      storage_in    = storage_ff;
      tariff_in     = tariff_ff;
      subunit_in    = subunit_ff;
      held_vif_in   = held_vif_ff;
      bytes_left_in = bytes_left_ff;
      rec_len_in    = rec_len_ff;
      rec_start_in  = rec_start_ff;
      res_valid     = 1'b0;
      was_data      = 1'b0;
      res_kind      = KIND_HEADER;
      res_value     = 8'd0;
      res_pos       = 8'd0;
      res_last      = 1'b0;

      if (!halted_ff) begin
         case (phase_ff)
            PH_DIF: begin
               if (!cmd_item.filler) begin
                  held_dif_in   = b;
                  held_var_in   = cmd_item.var_len;
                  held_len_in   = cmd_item.fixed_len;
                  dife_count_in = 4'd0;
                  storage_in    = {40'd0, b[6]};
                  tariff_in     = 20'd0;
                  subunit_in    = 10'd0;
                  held_vif_in   = 7'd0;
                  bytes_left_in = 8'd0;
                  rec_len_in    = 8'd0;
                  rec_start_in  = 8'd0;
                  if (cmd_item.bad) begin
                     res_valid = 1'b1;
                     res_kind  = KIND_STOP;
                     res_pos   = position_ff;
                  end
               end
            end
            PH_DIFE: begin
               // walk extra DIFEs but drop their bits
               if (dife_count_ff < MaxDife) begin
                  subunit_in    = subunit_ff | su_bits[9:0];
                  tariff_in     = tariff_ff | tf_bits[19:0];
                  storage_in    = storage_ff | st_bits[40:0];
                  dife_count_in = dife_count_ff + 4'd1;
               end
            end
            PH_VIF, PH_VIFE: begin
               if (phase_ff == PH_VIF) held_vif_in = b[6:0];
               if (!b[7] && !held_var_ff) begin
                  rec_len_in    = {4'd0, held_len_ff};
                  rec_start_in  = next_pos;
                  bytes_left_in = {4'd0, held_len_ff};
                  res_valid     = 1'b1;
                  res_pos       = next_pos;
                  res_last      = (held_len_ff == 4'd0);
               end
            end
            PH_VARLEN: begin
               rec_len_in    = b;
               rec_start_in  = next_pos;
               bytes_left_in = b;
               res_valid     = 1'b1;
               res_pos       = next_pos;
               res_last      = (b == 8'd0);
            end
            PH_DATA: begin
               was_data = 1'b1;
               if (bytes_left_ff != 8'd0) bytes_left_in = bytes_left_ff - 8'd1;
               res_valid = 1'b1;
               res_kind  = KIND_DATA;
               res_value = b;
               res_pos   = rec_start_ff;
               res_last  = (bytes_left_ff <= 8'd1);
            end
            default: ;
         endcase
      end

      if (eot && !halt_step && (phase_step != PH_DIF)) begin
         res_valid = 1'b1;
         res_kind  = KIND_TRUNC;
         res_value = was_data ? b : 8'd0;
         res_pos   = rec_start_in;
         res_last  = 1'b1;
      end

      res.kind           = res_kind;
      res.measure_type   = held_dif_in[5:4];
      res.data_coding    = held_dif_in[3:0];
      res.vif_code       = held_vif_in;
      res.storage_number = storage_in;
      res.tariff_number  = tariff_in;
      res.subunit_number = subunit_in;
      res.record_length  = rec_len_in;
      res.data_value     = res_value;
      res.byte_position  = res_pos;
      res.record_last    = res_last;

      position_in = next_pos;
      if (eot) begin
         held_dif_in   = 8'd0;
         held_var_in   = 1'b0;
         held_len_in   = 4'd0;
         dife_count_in = 4'd0;
         storage_in    = 41'd0;
         tariff_in     = 20'd0;
         subunit_in    = 10'd0;
         held_vif_in   = 7'd0;
         bytes_left_in = 8'd0;
         rec_len_in    = 8'd0;
         rec_start_in  = 8'd0;
         position_in   = 8'd0;
      end
   end

   assign out_count_in = out_count_ff + {1'b0, out_write} - {1'b0, out_read};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_DIF;
         halted_ff     <= 1'b0;
         held_dif_ff   <= 8'd0;
         held_var_ff   <= 1'b0;
         held_len_ff   <= 4'd0;
         dife_count_ff <= 4'd0;
         storage_ff    <= 41'd0;
         tariff_ff     <= 20'd0;
         subunit_ff    <= 10'd0;
         held_vif_ff   <= 7'd0;
         bytes_left_ff <= 8'd0;
         position_ff   <= 8'd0;
         rec_len_ff    <= 8'd0;
         rec_start_ff  <= 8'd0;
         out_wr_ff     <= 1'b0;
         out_rd_ff     <= 1'b0;
         out_count_ff  <= 2'd0;
      end else begin
         if (take) begin
            phase_ff      <= phase_in;
            halted_ff     <= halted_in;
            held_dif_ff   <= held_dif_in;
            held_var_ff   <= held_var_in;
            held_len_ff   <= held_len_in;
            dife_count_ff <= dife_count_in;
            storage_ff    <= storage_in;
            tariff_ff     <= tariff_in;
            subunit_ff    <= subunit_in;
            held_vif_ff   <= held_vif_in;
            bytes_left_ff <= bytes_left_in;
            position_ff   <= position_in;
            rec_len_ff    <= rec_len_in;
            rec_start_ff  <= rec_start_in;
         end
         if (out_write) out_wr_ff <= !out_wr_ff;
         if (out_read) out_rd_ff <= !out_rd_ff;
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_write) begin
         rsp_mem_ff[out_wr_ff] <= res;
      end
   end

endmodule

### hw/rtl/mbus_data_record_parser_unit.sv
// Channel | Direction | Handshake          | Payload
// req     | in        | req_push / req_full  | in_byte, end_of_telegram
// rsp     | out       | rsp_pop / rsp_empty  | record header, data byte, stop, truncation
//
// One byte per cycle sustained while the rsp side keeps popping; a byte's result, if any,
// passes from the two-entry byte queue to the parse step, which writes it into the
// result queue that drives the rsp ports.
// Reset is synchronous and empties both queues; parsing restarts at a DIF.
// A stalled rsp side fills the two-entry result queue, then the byte queue, and
// only then raises req_full.
module mbus_data_record_parser_unit #(
   parameter int MAX_DIFE = mdrp_pkg::MAX_DIFE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_telegram,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_out_kind,
   output logic [1:0]  rsp_measure_type,
   output logic [3:0]  rsp_data_coding,
   output logic [6:0]  rsp_vif_code,
   output logic [40:0] rsp_storage_number,
   output logic [19:0] rsp_tariff_number,
   output logic [9:0]  rsp_subunit_number,
   output logic [7:0]  rsp_record_length,
   output logic [7:0]  rsp_data_value,
   output logic [7:0]  rsp_byte_position,
   output logic        rsp_record_last
);
   import mdrp_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_item;
   rsp_type rsp_item;

   mdrp_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_in_byte         (req_in_byte),
      .req_end_of_telegram (req_end_of_telegram),
      .cmd_valid           (cmd_valid),
      .cmd_item            (cmd_item),
      .cmd_pop             (cmd_pop)
   );

   mdrp_back #(
      .MAX_DIFE (MAX_DIFE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_item  (cmd_item),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   assign rsp_out_kind       = rsp_item.kind;
   assign rsp_measure_type   = rsp_item.measure_type;
   assign rsp_data_coding    = rsp_item.data_coding;
   assign rsp_vif_code       = rsp_item.vif_code;
   assign rsp_storage_number = rsp_item.storage_number;
   assign rsp_tariff_number  = rsp_item.tariff_number;
   assign rsp_subunit_number = rsp_item.subunit_number;
   assign rsp_record_length  = rsp_item.record_length;
   assign rsp_data_value     = rsp_item.data_value;
   assign rsp_byte_position  = rsp_item.byte_position;
   assign rsp_record_last    = rsp_item.record_last;

endmodule

### tb/mbus_data_record_parser_checker.sv
`timescale 1ns / 100ps

module mbus_data_record_parser_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_telegram,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [1:0]  rsp_out_kind,
   input  logic [1:0]  rsp_measure_type,
   input  logic [3:0]  rsp_data_coding,
   input  logic [6:0]  rsp_vif_code,
   input  logic [40:0] rsp_storage_number,
   input  logic [19:0] rsp_tariff_number,
   input  logic [9:0]  rsp_subunit_number,
   input  logic [7:0]  rsp_record_length,
   input  logic [7:0]  rsp_data_value,
   input  logic [7:0]  rsp_byte_position,
   input  logic        rsp_record_last,
   output int          error_count,
   output int          waiting
);
   import mdrp_pkg::*;

   localparam int DIFE_LIMIT = MAX_DIFE_DEFAULT;

   // parser state as seen from the byte stream
   phase_type   stage;
   logic [7:0]  dif_hold;
   int          ext_count;
   logic [40:0] storage;
   logic [19:0] tariff;
   logic [9:0]  subunit;
   logic [6:0]  vif_hold;
   logic [7:0]  remaining;
   logic [7:0]  offset;
   logic        stopped;
   logic [7:0]  length;
   logic [7:0]  first_pos;

   rsp_type     records_due[$];
   rsp_type     next_record;
   rsp_type     want;
   rsp_type     got;
   logic        made;

   initial begin
      error_count = 0;
      waiting = 0;
   end

   function automatic logic [7:0] fixed_bytes(input logic [3:0] coding);
      case (coding)
         4'h1, 4'h9: return 8'd1;
         4'h2, 4'hA: return 8'd2;
         4'h3, 4'hB: return 8'd3;
         4'h4, 4'h5, 4'hC: return 8'd4;
         4'h6, 4'hE: return 8'd6;
         4'h7: return 8'd8;
         default: return 8'd0;
      endcase
   endfunction

   function automatic rsp_type snapshot(input logic [1:0] kind, input logic [7:0] value,
                                        input logic [7:0] where, input logic last);
      rsp_type s;
      s.kind           = kind;
      s.measure_type   = dif_hold[5:4];
      s.data_coding    = dif_hold[3:0];
      s.vif_code       = vif_hold;
      s.storage_number = storage;
      s.tariff_number  = tariff;
      s.subunit_number = subunit;
      s.record_length  = length;
      s.data_value     = value;
      s.byte_position  = where;
      s.record_last    = last;
      return s;
   endfunction

   function automatic void clear_state();
      stage     = PH_DIF;
      dif_hold  = '0;
      ext_count = 0;
      storage   = '0;
      tariff    = '0;
      subunit   = '0;
      vif_hold  = '0;
      remaining = '0;
      offset    = '0;
      stopped   = 1'b0;
      length    = '0;
      first_pos = '0;
   endfunction

   function automatic void open_record(input logic [7:0] dif);
      dif_hold  = dif;
      ext_count = 0;
      storage   = {40'd0, dif[6]};
      tariff    = '0;
      subunit   = '0;
      vif_hold  = '0;
      remaining = '0;
      length    = '0;
      first_pos = '0;
   endfunction

   function automatic rsp_type set_length(input logic [7:0] len, input logic [7:0] after);
      length    = len;
      first_pos = after;
      if (len == 8'd0) begin
         stage = PH_DIF;
         return snapshot(KIND_HEADER, 8'd0, first_pos, 1'b1);
      end
      remaining = len;
      stage     = PH_DATA;
      return snapshot(KIND_HEADER, 8'd0, first_pos, 1'b0);
   endfunction

   // identification done: either wait for a length byte or emit the header
   function automatic void ident_done(input logic [7:0] after, output logic hit,
                                      output rsp_type r);
      hit = 1'b0;
      r   = '0;
      if (dif_hold[3:0] == CODING_VAR) begin
         stage = PH_VARLEN;
      end else begin
         r   = set_length(fixed_bytes(dif_hold[3:0]), after);
         hit = 1'b1;
      end
   endfunction

   function automatic void parse_byte(input logic [7:0] b, input logic eot,
                                      output logic hit, output rsp_type r);
      logic [7:0] here;
      logic [7:0] after;
      logic       was_data;
      int         k;
      here     = offset;
      after    = offset + 8'd1;
      was_data = 1'b0;
      hit      = 1'b0;
      r        = '0;
      if (!stopped) begin
         case (stage)
            PH_DIF: begin
               if (b != FILLER_DIF) begin
                  open_record(b);
                  if (b[3:0] == CODING_SPEC) begin
                     stopped = 1'b1;
                     r       = snapshot(KIND_STOP, 8'd0, here, 1'b0);
                     hit     = 1'b1;
                  end else begin
                     stage = b[7] ? PH_DIFE : PH_VIF;
                  end
               end
            end
            PH_DIFE: begin
               // walk extensions past the limit, but drop their bits
               if (ext_count < DIFE_LIMIT && ext_count < 15) begin
                  k         = ext_count;
                  subunit   = subunit | (10'(b[6]) << k);
                  tariff    = tariff | (20'(b[5:4]) << (2 * k));
                  storage   = storage | (41'(b[3:0]) << (1 + 4 * k));
                  ext_count = k + 1;
               end
               if (!b[7]) stage = PH_VIF;
            end
            PH_VIF: begin
               vif_hold = b[6:0];
               if (b[7]) stage = PH_VIFE;
               else ident_done(after, hit, r);
            end
            PH_VIFE: begin
               if (!b[7]) ident_done(after, hit, r);
            end
            PH_VARLEN: begin
               r   = set_length(b, after);
               hit = 1'b1;
            end
            default: begin
               was_data = 1'b1;
               if (remaining > 0) remaining = remaining - 8'd1;
               if (remaining == 0) begin
                  r     = snapshot(KIND_DATA, b, first_pos, 1'b1);
                  stage = PH_DIF;
               end else begin
                  r = snapshot(KIND_DATA, b, first_pos, 1'b0);
               end
               hit = 1'b1;
            end
         endcase
      end
      if (eot) begin
         // an unfinished record replaces whatever this byte produced
         if (!stopped && stage != PH_DIF) begin
            r   = snapshot(KIND_TRUNC, was_data ? b : 8'd0, first_pos, 1'b1);
            hit = 1'b1;
         end
         clear_state();
      end else begin
         offset = after;
      end
   endfunction

   function automatic void check_field(input string name, input logic [40:0] want_v,
                                       input logic [40:0] got_v);
      if (want_v !== got_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         records_due.delete();
      end else begin
         if (req_push && !req_full) begin
            parse_byte(req_in_byte, req_end_of_telegram, made, next_record);
            if (made) records_due.insert(records_due.size(), next_record);
         end
         if (rsp_pop && !rsp_empty) begin
            got = {rsp_out_kind, rsp_measure_type, rsp_data_coding, rsp_vif_code,
                   rsp_storage_number, rsp_tariff_number, rsp_subunit_number,
                   rsp_record_length, rsp_data_value, rsp_byte_position, rsp_record_last};
            if (records_due.size() == 0) begin
               error_count++;
               $display("%0t: unexpected beat, expected none, actual 0x%0h", $time, got);
            end else begin
               want = records_due.pop_front();
               check_field("out_kind", 41'(want.kind), 41'(got.kind));
               check_field("measure_type", 41'(want.measure_type), 41'(got.measure_type));
               check_field("data_coding", 41'(want.data_coding), 41'(got.data_coding));
               check_field("vif_code", 41'(want.vif_code), 41'(got.vif_code));
               check_field("storage_number", want.storage_number, got.storage_number);
               check_field("tariff_number", 41'(want.tariff_number), 41'(got.tariff_number));
               check_field("subunit_number", 41'(want.subunit_number),
                           41'(got.subunit_number));
               check_field("record_length", 41'(want.record_length), 41'(got.record_length));
               check_field("data_value", 41'(want.data_value), 41'(got.data_value));
               check_field("byte_position", 41'(want.byte_position), 41'(got.byte_position));
               check_field("record_last", 41'(want.record_last), 41'(got.record_last));
            end
         end
      end
      waiting <= records_due.size();
   end

endmodule

### tb/mbus_data_record_parser_unit_test.sv
`timescale 1ns / 100ps

module mbus_data_record_parser_unit_test;
   import mdrp_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int PHASE_BYTES = 270;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_in_byte = 8'd0;
   logic        req_end_of_telegram = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_out_kind;
   logic [1:0]  rsp_measure_type;
   logic [3:0]  rsp_data_coding;
   logic [6:0]  rsp_vif_code;
   logic [40:0] rsp_storage_number;
   logic [19:0] rsp_tariff_number;
   logic [9:0]  rsp_subunit_number;
   logic [7:0]  rsp_record_length;
   logic [7:0]  rsp_data_value;
   logic [7:0]  rsp_byte_position;
   logic        rsp_record_last;

   int          error_count;
   int          waiting;
   int          quiet_cycles = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   logic        hold_pop = 1'b0;
   int          bytes_sent = 0;
   logic [7:0]  telegram[$];

   mbus_data_record_parser_unit DUT (.*);

   mbus_data_record_parser_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || hold_pop) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic int coding_bytes(input logic [3:0] coding);
      case (coding)
         4'h1, 4'h9: return 1;
         4'h2, 4'hA: return 2;
         4'h3, 4'hB: return 3;
         4'h4, 4'h5, 4'hC: return 4;
         4'h6, 4'hE: return 6;
         4'h7: return 8;
         default: return 0;
      endcase
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic eot);
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push            <= 1'b1;
      req_in_byte         <= b;
      req_end_of_telegram <= eot;
      @(posedge clock);
      while (req_full) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_telegram();
      foreach (telegram[i]) send_beat(telegram[i], i == telegram.size() - 1);
   endtask

   task automatic add_record();
      logic [3:0] coding;
      logic [7:0] dif;
      logic [7:0] vif;
      int         n_ext;
      int         n_vife;
      int         len;
      int         pick;
      coding = 4'($urandom_range(14));
      dif    = {1'b0, 3'($urandom_range(7)), coding};
      dif[7] = ($urandom_range(99) < 40);
      telegram.insert(telegram.size(), dif);
      if (dif[7]) begin
         n_ext = ($urandom_range(9) == 0) ? $urandom_range(13, 9) : $urandom_range(3, 1);
         for (int i = 0; i < n_ext; i++)
            telegram.insert(telegram.size(), {i < n_ext - 1, 7'($urandom_range(127))});
      end
      vif    = 8'($urandom_range(255));
      vif[7] = ($urandom_range(99) < 25);
      telegram.insert(telegram.size(), vif);
      if (vif[7]) begin
         n_vife = $urandom_range(3, 1);
         for (int i = 0; i < n_vife; i++)
            telegram.insert(telegram.size(), {i < n_vife - 1, 7'($urandom_range(127))});
      end
      if (coding == CODING_VAR) begin
         pick = $urandom_range(99);
         if (pick < 85) len = $urandom_range(8);
         else if (pick < 95) len = $urandom_range(40, 9);
         else len = $urandom_range(255, 200);
         telegram.insert(telegram.size(), 8'(len));
      end else begin
         len = coding_bytes(coding);
      end
      repeat (len) telegram.insert(telegram.size(), 8'($urandom_range(255)));
   endtask

   // mostly well-formed telegrams; some cut short, some stopped, some noise
   task automatic build_telegram();
      int shape;
      int n_rec;
      int cut;
      logic [7:0] stop_dif;
      telegram.delete();
      shape = $urandom_range(99);
      if (shape < 90) begin
         n_rec = $urandom_range(4, 1);
         repeat (n_rec) begin
            if ($urandom_range(99) < 20) telegram.insert(telegram.size(), FILLER_DIF);
            add_record();
         end
         if ($urandom_range(99) < 10) telegram.insert(telegram.size(), FILLER_DIF);
      end
      if (shape >= 70 && shape < 82) begin
         cut = $urandom_range(telegram.size(), 1);
         while (telegram.size() > cut) void'(telegram.pop_back());
      end else if (shape >= 82 && shape < 90) begin
         stop_dif = {4'($urandom_range(15)), CODING_SPEC};
         if (stop_dif == FILLER_DIF) stop_dif = 8'hFF;
         telegram.insert(telegram.size(), stop_dif);
         repeat ($urandom_range(5)) telegram.insert(telegram.size(), 8'($urandom_range(255)));
      end else if (shape >= 90) begin
         repeat ($urandom_range(12, 1))
            telegram.insert(telegram.size(), 8'($urandom_range(255)));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // filler, empty record, DIFE chain with VIFE, zero-length with bit 6, variable length;
      // then a special DIF
      telegram = '{8'h2F, 8'h00, 8'h13, 8'h84, 8'hFF, 8'h40, 8'hFD, 8'h0B,
                   8'h11, 8'h22, 8'h33, 8'h44, 8'h48, 8'h7F, 8'h0D, 8'h78,
                   8'h02, 8'hFF, 8'h00};
      send_telegram();
      telegram = '{8'h0F, 8'hAA};
      send_telegram();
      // truncated inside data, then at the DIF itself
      telegram = '{8'h04, 8'h13, 8'hAA};
      send_telegram();
      telegram = '{8'h8D};
      send_telegram();

      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 77; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 77; end
            default: begin idle_pct = 6; stall_pct = 6; end
         endcase
         if (mode == 0) begin
            // hold the result side off long enough for the input to back up
            fork
               begin
                  hold_pop <= 1'b1;
                  repeat (150) @(posedge clock);
                  hold_pop <= 1'b0;
               end
            join_none
         end
         while (bytes_sent < 25 + PHASE_BYTES * (mode + 1)) begin
            build_telegram();
            send_telegram();
            // a stretch with no sender gaps now and then
            if ((mode == 1 || mode == 3) && $urandom_range(9) == 0)
               idle_pct = (idle_pct == 0) ? ((mode == 1) ? 77 : 6) : 0;
         end
      end
      req_push <= 1'b0;

      @(posedge clock);
      while (waiting != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### files.f
hw/rtl/mdrp_pkg.sv
hw/rtl/mdrp_front.sv
hw/rtl/mdrp_back.sv
hw/rtl/mbus_data_record_parser_unit.sv
tb/mbus_data_record_parser_checker.sv
tb/mbus_data_record_parser_unit_test.sv
